[src/rusi_pkg.sv]
// Shared constants, types and arithmetic helpers of the ray/box slab intersector.
`timescale 1ns / 1ps
package rusi_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int NUM_AXES  = 3;
    // Dividend magnitude: |bound - origin| < 2^32, shifted by the fraction bits
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int REM_W     = DATA_W;
    localparam int EXT_W     = DATA_W + 2;
    // Distance width with room for the unbounded marks
    localparam int T_W       = NUM_W + 3;
    // Prep register, one register per quotient bit, floor/sort register
    localparam int LANE_LAT  = NUM_W + 2;
    // Lanes, then the min/max register, then the output register
    localparam int PIPE_LAT  = LANE_LAT + 2;

    localparam logic signed [EXT_W-1:0] ONE_X   = EXT_W'(1) <<< FRAC_BITS;
    localparam logic signed [T_W-1:0]   T_MAX   = {1'b0, {(T_W-1){1'b1}}};
    localparam logic signed [T_W-1:0]   T_MIN   = {1'b1, {(T_W-1){1'b0}}};
    localparam logic signed [T_W-1:0]   SAT_MAX = T_W'({1'b0, {(DATA_W-1){1'b1}}});
    localparam logic signed [T_W-1:0]   SAT_MIN = -SAT_MAX - T_W'(1);

    typedef struct packed {
        logic signed [DATA_W-1:0] origin_x;
        logic signed [DATA_W-1:0] origin_y;
        logic signed [DATA_W-1:0] origin_z;
        logic signed [DATA_W-1:0] dir_x;
        logic signed [DATA_W-1:0] dir_y;
        logic signed [DATA_W-1:0] dir_z;
    } t_ray;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] t_near;
        logic signed [DATA_W-1:0] t_far;
    } t_res;

    // Per-axis slab as seen by the merge stage
    typedef struct packed {
        logic                  ok;
        logic signed [T_W-1:0] lo;
        logic signed [T_W-1:0] hi;
    } t_slab;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [NUM_W-1:0] num;
    } t_div;

    // One restoring step: shift in the next dividend bit, subtract when it fits
    function automatic t_div div_step(input t_div cur, input logic [REM_W-1:0] dmag);
        logic [REM_W:0] trial;
        logic [REM_W:0] diff;
        logic           qbit;
        t_div           nxt;
        trial   = {cur.rem, cur.num[NUM_W-1]};
        diff    = trial - {1'b0, dmag};
        qbit    = (trial >= {1'b0, dmag});
        nxt.rem = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
        nxt.num = {cur.num[NUM_W-2:0], qbit};
        return nxt;
    endfunction

    // Apply the quotient sign, rounding toward negative infinity
    function automatic logic signed [T_W-1:0] floor_fix(input t_div q, input logic neg);
        logic signed [T_W-1:0] mag;
        mag = $signed({{(T_W-NUM_W){1'b0}}, q.num});
        if (neg) begin
            return -mag - ((q.rem != '0) ? T_W'(1) : T_W'(0));
        end
        return mag;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [T_W-1:0] v);
        if (v > SAT_MAX) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
        if (v < SAT_MIN) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

[src/rusi_if.sv]
// Ready/valid channel interfaces for rays and intersection results.
`timescale 1ns / 1ps
interface rusi_ray_if;
    import rusi_pkg::*;
    logic valid;
    logic ready;
    t_ray payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rusi_res_if;
    import rusi_pkg::*;
    logic valid;
    logic ready;
    t_res payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/rusi_lane.sv]
// One axis lane: pipelined floor division for both slab planes, then sort into near/far.
`timescale 1ns / 1ps
module rusi_lane (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [rusi_pkg::DATA_W-1:0] i_origin,
    input  logic signed [rusi_pkg::DATA_W-1:0] i_dir,
    output rusi_pkg::t_slab                   o_slab
);
    import rusi_pkg::*;

    logic signed [EXT_W-1:0] ext_o;
    logic signed [EXT_W-1:0] ext_d;
    logic signed [EXT_W-1:0] diff_a;
    logic signed [EXT_W-1:0] diff_b;
    logic signed [EXT_W-1:0] mag_a;
    logic signed [EXT_W-1:0] mag_b;
    logic signed [EXT_W-1:0] mag_d;

    always_comb begin
        ext_o  = {{(EXT_W-DATA_W){i_origin[DATA_W-1]}}, i_origin};
        ext_d  = {{(EXT_W-DATA_W){i_dir[DATA_W-1]}}, i_dir};
        diff_a = -ONE_X - ext_o;
        diff_b = ONE_X - ext_o;
        mag_a  = diff_a[EXT_W-1] ? -diff_a : diff_a;
        mag_b  = diff_b[EXT_W-1] ? -diff_b : diff_b;
        mag_d  = ext_d[EXT_W-1] ? -ext_d : ext_d;
    end

    t_div             r_div_a  [0:NUM_W];
    t_div             r_div_b  [0:NUM_W];
    logic [REM_W-1:0] r_dmag   [0:NUM_W];
    logic             r_neg_a  [0:NUM_W];
    logic             r_neg_b  [0:NUM_W];
    logic             r_dzero  [0:NUM_W];
    logic             r_inside [0:NUM_W];

    // Operand prep
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div_a[0].rem <= '0;
            r_div_a[0].num <= {mag_a[DATA_W-1:0], {FRAC_BITS{1'b0}}};
            r_div_b[0].rem <= '0;
            r_div_b[0].num <= {mag_b[DATA_W-1:0], {FRAC_BITS{1'b0}}};
            r_dmag[0]      <= mag_d[REM_W-1:0];
            r_neg_a[0]     <= diff_a[EXT_W-1] ^ i_dir[DATA_W-1];
            r_neg_b[0]     <= diff_b[EXT_W-1] ^ i_dir[DATA_W-1];
            r_dzero[0]     <= (i_dir == '0);
            r_inside[0]    <= (ext_o >= -ONE_X) && (ext_o <= ONE_X);
        end
    end

    // One quotient bit per stage
    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div_a[k+1]  <= div_step(r_div_a[k], r_dmag[k]);
                r_div_b[k+1]  <= div_step(r_div_b[k], r_dmag[k]);
                r_dmag[k+1]   <= r_dmag[k];
                r_neg_a[k+1]  <= r_neg_a[k];
                r_neg_b[k+1]  <= r_neg_b[k];
                r_dzero[k+1]  <= r_dzero[k];
                r_inside[k+1] <= r_inside[k];
            end
        end
    end

    logic signed [T_W-1:0] ta;
    logic signed [T_W-1:0] tb;
    t_slab                 n_slab;
    t_slab                 r_slab;

    always_comb begin
        ta = floor_fix(r_div_a[NUM_W], r_neg_a[NUM_W]);
        tb = floor_fix(r_div_b[NUM_W], r_neg_b[NUM_W]);
        if (r_dzero[NUM_W]) begin
            // Parallel ray: unbounded slab, or a miss when outside it
            n_slab.ok = r_inside[NUM_W];
            n_slab.lo = T_MIN;
            n_slab.hi = T_MAX;
        end else begin
            n_slab.ok = 1'b1;
            n_slab.lo = (ta < tb) ? ta : tb;
            n_slab.hi = (ta < tb) ? tb : ta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_slab <= n_slab;
        end
    end

    assign o_slab = r_slab;

endmodule

[src/rusi_merge.sv]
// Merge stage: combine the three slabs, decide hit/miss and saturate the distances.
`timescale 1ns / 1ps
module rusi_merge (
    input  logic            i_clk,
    input  logic            i_en,
    input  rusi_pkg::t_slab i_slab [rusi_pkg::NUM_AXES],
    output rusi_pkg::t_res  o_res
);
    import rusi_pkg::*;

    logic                  n_ok;
    logic signed [T_W-1:0] n_tmin;
    logic signed [T_W-1:0] n_tmax;
    logic                  r_ok;
    logic signed [T_W-1:0] r_tmin;
    logic signed [T_W-1:0] r_tmax;
    t_res                  n_res;
    t_res                  r_res;

    always_comb begin
        n_ok   = 1'b1;
        n_tmin = T_MIN;
        n_tmax = T_MAX;
        for (int a = 0; a < NUM_AXES; a++) begin
            n_ok = n_ok && i_slab[a].ok;
            if (i_slab[a].lo > n_tmin) begin
                n_tmin = i_slab[a].lo;
            end
            if (i_slab[a].hi < n_tmax) begin
                n_tmax = i_slab[a].hi;
            end
        end
    end

    always_comb begin
        n_res = '0;
        if (r_ok && !r_tmax[T_W-1] && (r_tmin <= r_tmax)) begin
            n_res.hit    = 1'b1;
            n_res.t_near = sat32(r_tmin);
            n_res.t_far  = sat32(r_tmax);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok   <= n_ok;
            r_tmin <= n_tmin;
            r_tmax <= n_tmax;
            r_res  <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

[src/ray_unit_box_slab_intersect.sv]
// Top level: three axis lanes in parallel feeding the merge stage, with valid tracking.
//
//  channel  | dir | payload                                  | handshake
//  ---------+-----+------------------------------------------+-------------
//  i_ray    | in  | origin_x/y/z, dir_x/y/z (signed Q16.16)  | valid/ready
//  o_res    | out | hit, t_near, t_far (signed Q16.16)       | valid/ready
//
// One ray per cycle while the output is not stalled; the PIPE_LAT registers are the 48-stage
// divider in each lane plus prep, floor/sort, min/max and output registers.
// Synchronous active-low reset clears the valid pipeline only.
// A stalled output freezes the whole pipeline; while the output register is
// empty or drains the pipeline advances, and bubbles travel with the data.
`timescale 1ns / 1ps
module ray_unit_box_slab_intersect (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rusi_ray_if.sink          i_ray,
    rusi_res_if.source        o_res
);
    import rusi_pkg::*;

    logic                r_vld [PIPE_LAT];
    logic                en;
    t_slab               slab [NUM_AXES];
    logic signed [DATA_W-1:0] origin [NUM_AXES];
    logic signed [DATA_W-1:0] dir    [NUM_AXES];

    assign en          = !r_vld[PIPE_LAT-1] || o_res.ready;
    assign i_ray.ready = en;

    assign origin[0] = i_ray.payload.origin_x;
    assign origin[1] = i_ray.payload.origin_y;
    assign origin[2] = i_ray.payload.origin_z;
    assign dir[0]    = i_ray.payload.dir_x;
    assign dir[1]    = i_ray.payload.dir_y;
    assign dir[2]    = i_ray.payload.dir_z;

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
        rusi_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_origin (origin[a]),
            .i_dir    (dir[a]),
            .o_slab   (slab[a])
        );
    end

    rusi_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_slab (slab),
        .o_res  (o_res.payload)
    );

    // Advance the valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < PIPE_LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_ray.valid;
            for (int s = 1; s < PIPE_LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    assign o_res.valid = r_vld[PIPE_LAT-1];

endmodule

[src/rusi_chk.sv]
// Port-level checker for the slab intersector, bound to the top level.
`timescale 1ns / 1ps
module rusi_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic                               i_hit,
    input logic signed [rusi_pkg::DATA_W-1:0] i_t_near,
    input logic signed [rusi_pkg::DATA_W-1:0] i_t_far
);
    import rusi_pkg::*;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_hit |-> (i_t_near == '0) && (i_t_far == '0))
        else $error("miss result carries nonzero distances");

    a_hit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_hit |-> (i_t_near <= i_t_far) && !i_t_far[DATA_W-1])
        else $error("hit with near after far or negative far");

    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("input stalled while output can move");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_hit)
            && $stable(i_t_near) && $stable(i_t_far))
        else $error("stalled result changed");

endmodule

bind ray_unit_box_slab_intersect rusi_chk u_rusi_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_ray.valid),
    .i_in_ready  (i_ray.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_hit       (o_res.payload.hit),
    .i_t_near    (o_res.payload.t_near),
    .i_t_far     (o_res.payload.t_far)
);
